FILE: src/rbf_pkg.sv
// Shared types and constants for the ring buffer FIFO.
// Holds the storage geometry, operation and status codes and pointer helpers.
// No dependencies.
`default_nettype none

package rbf_pkg;

   localparam int DEPTH      = 16;
   localparam int WORD_WIDTH = 32;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CAP_W      = 5;
   localparam int OP_W       = 3;
   localparam int STATUS_W   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH       = 3'd0,
      OP_POP        = 3'd1,
      OP_PEEK_FRONT = 3'd2,
      OP_PEEK_BACK  = 3'd3,
      OP_CLEAR      = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Capacity register saturated into 1..DEPTH.
   function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
      logic [CNT_W-1:0] res;
      if (cap == '0) begin
         res = CNT_W'(1);
      end else if (32'(cap) > DEPTH) begin
         res = CNT_W'(DEPTH);
      end else begin
         res = CNT_W'(cap);
      end
      return res;
   endfunction

   // Pointer increment that wraps at the effective capacity.
   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] nxt;
      nxt = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
      return (nxt >= (CNT_W+1)'(cap)) ? '0 : IDX_W'(nxt);
   endfunction

endpackage

`default_nettype wire

FILE: src/rbf_store.sv
// Word storage for the ring buffer FIFO: one write port and one read port.
// Read data is registered and updates only when a read is enabled.
// Depends on rbf_pkg.
`default_nettype none

module rbf_store
   import rbf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [IDX_W-1:0]      wr_addr,
   input  wire logic [WORD_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [IDX_W-1:0]      rd_addr,
   output      logic [WORD_WIDTH-1:0] rd_data
);

   logic [WORD_WIDTH-1:0] mem [DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/ring_buffer_fifo.sv
// Each accepted operation moves to s1, then to the output register fed by the
// registered storage read; one operation per cycle unless rsp_tready stalls.
// Reset empties the queue and sets the capacity register to its full size of 16.
// Storage contents are not cleared; a capacity write also empties the queue.
// Depends on rbf_pkg and rbf_store.
`default_nettype none

module ring_buffer_fifo
   import rbf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [2:0] operation, [34:3] push_data, [39:35] zero
   input  wire logic [39:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] status, [33:2] read_data, [38:34] occupancy, [39] zero
   output      logic [39:0] rsp_tdata,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [CAP_W-1:0] csr_data
);

   logic [CAP_W-1:0]      capacity_ff, capacity_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  s1_valid_ff, s1_valid_in;
   status_type            s1_status_ff, s1_status_in;
   logic                  s1_rd_ff, s1_rd_in;
   logic [CNT_W-1:0]      s1_occ_ff, s1_occ_in;

   logic                  out_valid_ff, out_valid_in;
   status_type            out_status_ff;
   logic [WORD_WIDTH-1:0] out_data_ff;
   logic [CNT_W-1:0]      out_occ_ff;

   logic                  req_xfer, csr_xfer, s1_move;
   logic [CNT_W-1:0]      cap;
   op_type                op;
   logic [WORD_WIDTH-1:0] push_data;
   logic                  wr_en, rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [WORD_WIDTH-1:0] rd_data;

   assign op        = op_type'(req_tdata[2:0]);
   assign push_data = req_tdata[34:3];
   assign cap       = eff_capacity(capacity_ff);

   assign csr_ready  = 1'b1;
   assign csr_xfer   = csr_valid & csr_ready;
   assign s1_move    = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_move;
   assign req_xfer   = req_tvalid & req_tready;

   always_comb begin
      capacity_in  = capacity_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      s1_status_in = ST_OK;
      s1_rd_in     = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      if (req_xfer) begin
         case (op)
            OP_PUSH: begin
               if (count_ff >= cap) begin
                  s1_status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  tail_in  = advance(tail_ff, cap);
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  s1_status_in = ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  s1_rd_in = 1'b1;
                  count_in = count_ff - CNT_W'(1);
                  head_in  = advance(head_ff, cap);
               end
            end
            OP_PEEK_FRONT: begin
               if (count_ff == '0) begin
                  s1_status_in = ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  s1_rd_in = 1'b1;
               end
            end
            OP_PEEK_BACK: begin
               if (count_ff == '0) begin
                  s1_status_in = ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  s1_rd_in = 1'b1;
                  rd_addr  = (tail_ff == '0) ? IDX_W'(cap - CNT_W'(1))
                                             : tail_ff - IDX_W'(1);
               end
            end
            OP_CLEAR: begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
      if (csr_xfer) begin
         capacity_in = csr_data;
         head_in     = '0;
         tail_in     = '0;
         count_in    = '0;
      end
      s1_occ_in    = count_in;
      s1_valid_in  = req_xfer | (s1_valid_ff & ~s1_move);
      out_valid_in = s1_move | (out_valid_ff & ~rsp_tready);
   end

   rbf_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (push_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_W'(DEPTH);
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_status_ff <= s1_status_in;
         s1_rd_ff     <= s1_rd_in;
         s1_occ_ff    <= s1_occ_in;
      end
      if (s1_move) begin
         out_status_ff <= s1_status_ff;
         out_data_ff   <= s1_rd_ff ? rd_data : '0;
         out_occ_ff    <= s1_occ_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_occ_ff, out_data_ff, out_status_ff};

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap)
      else $error("occupancy exceeds effective capacity");

   a_refused_push_holds: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && op == OP_PUSH && count_ff >= cap && !csr_xfer) |=>
         $stable(count_ff) && $stable(tail_ff))
      else $error("refused push changed queue state");

   a_read_only_when_ok: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_rd_ff) |-> s1_status_ff == ST_OK)
      else $error("storage read issued for a refused operation");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> out_valid_ff && $stable(out_data_ff))
      else $error("pending result lost while stalled");

endmodule

`default_nettype wire
